FILE: rtl/abcd_pkg.sv
// Package for the analog button click detector.
// Holds field widths, event codes, register indexes and shared structs.
`timescale 1ns / 1ps

package abcd_pkg;

  localparam int unsigned ADC_W = 10;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MS_W = 16;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PRESS_WINDOW = 50;
  localparam int unsigned RELEASE_HIGH = 1000;
  localparam int unsigned RELEASE_LOW = 20;
  localparam int unsigned CRAZY_COUNT = 10;
  localparam int unsigned PRESS_LEVEL_RST = 512;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CODE_W-1:0] EV_PRESS = 5'd0;
  localparam logic [CODE_W-1:0] EV_RELEASE = 5'd1;
  localparam logic [CODE_W-1:0] EV_CHANGE = 5'd2;
  localparam logic [CODE_W-1:0] EV_HOLD = 5'd3;
  localparam logic [CODE_W-1:0] EV_CLICK1 = 5'd4;
  localparam logic [CODE_W-1:0] EV_CRAZY = 5'd14;
  localparam logic [CODE_W-1:0] EV_LONG0 = 5'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_REPEAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTICLICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BISTABLE = 3'd4;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
    logic              two;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

FILE: rtl/abcd_in_if.sv
// Input channel of the click detector: one tick per request.
// Depends on abcd_pkg for the field widths.
`timescale 1ns / 1ps

interface abcd_in_if;
  import abcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADC_W-1:0]  adc_sample;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output adc_sample, output now_ms, input ready);
  modport sink (input valid, input adc_sample, input now_ms, output ready);
endinterface

FILE: rtl/abcd_out_if.sv
// Output channel of the click detector: one event per request.
// Depends on abcd_pkg for the field widths.
`timescale 1ns / 1ps

interface abcd_out_if;
  import abcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;
  logic              last_event;

  modport source (output valid, output event_code, output last_event, input ready);
  modport sink (input valid, input event_code, input last_event, output ready);
endinterface

FILE: rtl/abcd_front.sv
// Front part: configuration registers, button state and tick classification.
// Depends on abcd_pkg and abcd_in_if; pushes event entries into the queue.
`timescale 1ns / 1ps

module abcd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abcd_pkg::cfg_wr_t  cfg_i,
  abcd_in_if.sink            in_ch,
  input  logic               q_ready_i,
  output abcd_pkg::q_push_t  q_push_o
);
  import abcd_pkg::*;

  logic [ADC_W-1:0]  press_level_q;
  logic [MS_W-1:0]   hold_time_q;
  logic [MS_W-1:0]   hold_repeat_q;
  logic [MS_W-1:0]   multiclick_q;
  logic              bist_q;

  logic              pressed_q, pressed_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic [CNT_W-1:0]  click_q, click_d;
  logic [MS_W-1:0]   holds_q, holds_d;
  logic [TIME_W-1:0] thr_q, thr_d;

  logic [MS_W-1:0]   hold_time_nx;
  logic [MS_W-1:0]   hold_repeat_nx;
  logic              accept;
  logic signed [ADC_W+1:0] smp_s;
  logic signed [ADC_W+1:0] lvl_s;
  logic              in_win;
  logic              rel;
  logic [TIME_W-1:0] gap;
  logic              hold_fire;
  logic              has_ev;
  entry_t            ev;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = q_ready_i;

  assign smp_s = $signed({2'b00, in_ch.adc_sample});
  assign lvl_s = $signed({2'b00, press_level_q});
  assign in_win = (smp_s >= lvl_s - $signed((ADC_W+2)'(PRESS_WINDOW))) &&
                  (smp_s <= lvl_s + $signed((ADC_W+2)'(PRESS_WINDOW)));
  assign rel = (in_ch.adc_sample >= ADC_W'(RELEASE_HIGH)) ||
               (in_ch.adc_sample <= ADC_W'(RELEASE_LOW));
  assign gap = in_ch.now_ms - last_q;

  always_comb begin
    pressed_d = pressed_q;
    last_d = last_q;
    click_d = click_q;
    holds_d = holds_q;
    hold_fire = 1'b0;
    has_ev = 1'b0;
    ev = '0;
    if (!pressed_q && in_win) begin
      pressed_d = 1'b1;
      last_d = in_ch.now_ms;
      has_ev = 1'b1;
      ev.code0 = EV_PRESS;
      ev.code1 = EV_CHANGE;
      ev.two = 1'b1;
      if (click_q != '1) begin
        click_d = click_q + CNT_W'(1);
      end
    end else if (pressed_q && rel) begin
      pressed_d = 1'b0;
      last_d = in_ch.now_ms;
      has_ev = 1'b1;
      ev.code0 = EV_RELEASE;
      ev.code1 = EV_CHANGE;
      ev.two = 1'b1;
      if (bist_q && click_q != '1) begin
        click_d = click_q + CNT_W'(1);
      end
    end else if (!bist_q && pressed_q) begin
      if (click_q <= CNT_W'(1) && hold_time_q != '0 && gap > thr_q &&
          (hold_repeat_q != '0 || holds_q == '0)) begin
        has_ev = 1'b1;
        ev.code0 = EV_HOLD;
        if (holds_q != '1) begin
          hold_fire = 1'b1;
          holds_d = holds_q + MS_W'(1);
        end
      end
    end else if (multiclick_q == '0) begin
      holds_d = '0;
      click_d = '0;
    end else if (gap > TIME_W'(multiclick_q)) begin
      if (holds_q == '0) begin
        if (click_q >= CNT_W'(1) && click_q <= CNT_W'(CRAZY_COUNT)) begin
          has_ev = 1'b1;
          ev.code0 = CODE_W'(click_q) + EV_CLICK1 - CODE_W'(1);
          if (click_q == CNT_W'(CRAZY_COUNT)) begin
            ev.code1 = EV_CRAZY;
            ev.two = 1'b1;
          end
        end else if (click_q > CNT_W'(CRAZY_COUNT)) begin
          has_ev = 1'b1;
          ev.code0 = EV_CRAZY;
        end
      end else if (click_q >= CNT_W'(1) && click_q <= CNT_W'(CRAZY_COUNT + 1)) begin
        has_ev = 1'b1;
        ev.code0 = CODE_W'(click_q) + EV_LONG0 - CODE_W'(1);
      end
      holds_d = '0;
      click_d = '0;
    end
  end

  always_comb begin
    hold_time_nx = hold_time_q;
    hold_repeat_nx = hold_repeat_q;
    if (cfg_i.we && cfg_i.idx == CFG_HOLD_TIME) begin
      hold_time_nx = cfg_i.data[MS_W-1:0];
    end
    if (cfg_i.we && cfg_i.idx == CFG_HOLD_REPEAT) begin
      hold_repeat_nx = cfg_i.data[MS_W-1:0];
    end
    if (accept) begin
      if (holds_d == '0) begin
        thr_d = TIME_W'(hold_time_q);
      end else if (hold_fire) begin
        thr_d = thr_q + TIME_W'(hold_repeat_q);
      end else begin
        thr_d = thr_q;
      end
    end else begin
      thr_d = TIME_W'(hold_time_nx) + TIME_W'(holds_q) * TIME_W'(hold_repeat_nx);
    end
  end

  assign q_push_o.push = accept && has_ev;
  assign q_push_o.entry = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_level_q <= ADC_W'(PRESS_LEVEL_RST);
      hold_time_q <= '0;
      hold_repeat_q <= '0;
      multiclick_q <= '0;
      bist_q <= 1'b0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_PRESS_LEVEL: press_level_q <= cfg_i.data[ADC_W-1:0];
        CFG_HOLD_TIME:   hold_time_q <= cfg_i.data[MS_W-1:0];
        CFG_HOLD_REPEAT: hold_repeat_q <= cfg_i.data[MS_W-1:0];
        CFG_MULTICLICK:  multiclick_q <= cfg_i.data[MS_W-1:0];
        CFG_BISTABLE:    bist_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      last_q <= '0;
      click_q <= '0;
      holds_q <= '0;
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
      if (accept) begin
        pressed_q <= pressed_d;
        last_q <= last_d;
        click_q <= click_d;
        holds_q <= holds_d;
      end
    end
  end

  a_thr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> thr_q == TIME_W'(hold_time_q) + TIME_W'(holds_q) * TIME_W'(hold_repeat_q))
    else $error("hold threshold out of step with hold count");

  a_state_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(pressed_q) && $stable(click_q) && $stable(holds_q))
    else $error("button state changed without a tick");

  a_hold_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o.push && q_push_o.entry.code0 == EV_HOLD) |-> (pressed_q && !bist_q))
    else $error("hold event while released or bistable");
endmodule

FILE: rtl/abcd_queue.sv
// Short event queue between the front and back parts.
// Depends on abcd_pkg for the entry structs.
`timescale 1ns / 1ps

module abcd_queue #(
  parameter int unsigned DEPTH = abcd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abcd_pkg::q_push_t push_i,
  output logic              ready_o,
  output abcd_pkg::q_head_t head_o,
  input  logic              pop_i
);
  import abcd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              push;
  logic              pop;

  assign ready_o = cnt_q != CNT_QW'(DEPTH);
  assign push = push_i.push && ready_o;
  assign pop = pop_i && cnt_q != '0;
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_QW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_QW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> ready_o)
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("entry popped from an empty queue");

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + CNT_QW'(1))
    else $error("fill count missed a push");
endmodule

FILE: rtl/abcd_back.sv
// Back part: sends the one or two events of each queued entry in order.
// Depends on abcd_pkg and abcd_out_if.
`timescale 1ns / 1ps

module abcd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abcd_pkg::q_head_t head_i,
  output logic              pop_o,
  abcd_out_if.source        out_ch
);
  import abcd_pkg::*;

  logic slot_q, slot_d;
  logic last;
  logic take;

  assign last = slot_q || !head_i.entry.two;
  assign take = out_ch.valid && out_ch.ready;

  assign out_ch.valid = head_i.valid;
  assign out_ch.event_code = slot_q ? head_i.entry.code1 : head_i.entry.code0;
  assign out_ch.last_event = last;
  assign pop_o = take && last;

  always_comb begin
    slot_d = slot_q;
    if (take) begin
      slot_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
    end
  end
endmodule

FILE: rtl/analog_button_click_detector_unit.sv
// Top level of the analog button click detector.
// Depends on abcd_pkg, abcd_in_if, abcd_out_if, abcd_front, abcd_queue, abcd_back.
//
//   Channel   Direction  Contents                               Handshake
//   in_ch_i   sink       adc_sample, now_ms (one tick)          valid/ready
//   out_ch_o  source     event_code, last_event (one event)     valid/ready
//   cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i        write enable
//
// A tick is classified in the cycle it is accepted; one tick per cycle is taken
// while the event queue has room. Each event is one output transfer, so a tick with
// two events holds the output for two transfers and sets the sustained rate there.
// Reset is asynchronous and resets all control state at once; no clearing pass follows.
// A stalled output fills the queue of QUEUE_DEPTH entries, then input ready drops.
`timescale 1ns / 1ps

module analog_button_click_detector_unit #(
  parameter int unsigned QUEUE_DEPTH = abcd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [abcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [abcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  abcd_in_if.sink                         in_ch_i,
  abcd_out_if.source                      out_ch_o
);
  import abcd_pkg::*;

  cfg_wr_t cfg;
  q_push_t q_push;
  q_head_t q_head;
  logic    q_ready;
  logic    q_pop;

  assign cfg.we = cfg_we_i;
  assign cfg.idx = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  abcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_ch     (in_ch_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push)
  );

  abcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  abcd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_ch (out_ch_o)
  );
endmodule
